/* rtl/core/meu_pkg.sv */
// Package: operation codes, result actions, controller states and command types.
`timescale 1ns / 1ps
package meu_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned CNT_W = 6;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3,
        OP_MUL = 6'd4, OP_MULU = 6'd5, OP_MULT = 6'd6, OP_MULTU = 6'd7,
        OP_DIV = 6'd8, OP_DIVU = 6'd9, OP_DIV_HILO = 6'd10, OP_DIVU_HILO = 6'd11,
        OP_XOR = 6'd12, OP_NEG = 6'd13, OP_REM = 6'd14, OP_REMU = 6'd15,
        OP_SEQ = 6'd16, OP_SGE = 6'd17, OP_SGT = 6'd18, OP_SLE = 6'd19,
        OP_SLT = 6'd20, OP_SNE = 6'd21,
        OP_BEQ = 6'd22, OP_BNE = 6'd23, OP_BGE = 6'd24, OP_BLE = 6'd25,
        OP_BGT = 6'd26, OP_BLT = 6'd27, OP_BEQZ = 6'd28, OP_BNEZ = 6'd29,
        OP_BLEZ = 6'd30, OP_BGEZ = 6'd31, OP_BGTZ = 6'd32, OP_BLTZ = 6'd33,
        OP_JUMP = 6'd34, OP_LA = 6'd35, OP_LB = 6'd36, OP_LH = 6'd37,
        OP_LW = 6'd38, OP_SB = 6'd39, OP_SH = 6'd40, OP_SW = 6'd41,
        OP_MOVE = 6'd42, OP_MFHI = 6'd43, OP_MFLO = 6'd44
    } op_t;

    typedef enum logic [2:0] {
        ACT_REG = 3'd0, ACT_HILO = 3'd1, ACT_TAKEN = 3'd2,
        ACT_NOT_TAKEN = 3'd3, ACT_LOAD = 3'd4, ACT_STORE = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0, ST_DIV = 2'd1, ST_FIN = 2'd2, ST_OUT = 2'd3
    } state_t;

    typedef struct packed {
        logic load;      // capture request
        logic div_start; // set up divider
        logic div_step;  // one quotient bit
        logic finish;    // form result into output register
    } cmd_t;

    typedef struct packed {
        logic is_div;
        logic div_last;
    } sts_t;

    function automatic logic is_div_op(logic [5:0] op);
        return op == OP_DIV || op == OP_DIVU || op == OP_DIV_HILO ||
               op == OP_DIVU_HILO || op == OP_REM || op == OP_REMU;
    endfunction

endpackage

/* rtl/core/meu_ctrl.sv */
// Controller: sequences capture, divide iterations and result hand-off.
`timescale 1ns / 1ps
module meu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  meu_pkg::sts_t   sts,
    output meu_pkg::cmd_t   cmd
);
    meu_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= meu_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            meu_pkg::ST_IDLE: if (s_valid)
                state_next = sts.is_div ? meu_pkg::ST_DIV : meu_pkg::ST_FIN;
            meu_pkg::ST_DIV: if (sts.div_last) state_next = meu_pkg::ST_FIN;
            meu_pkg::ST_FIN: state_next = meu_pkg::ST_OUT;
            meu_pkg::ST_OUT: if (m_ready) state_next = meu_pkg::ST_IDLE;
            default: state_next = meu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == meu_pkg::ST_IDLE);
        m_valid = (state_reg == meu_pkg::ST_OUT);
        cmd.load = s_ready && s_valid;
        cmd.div_start = s_ready && s_valid && sts.is_div;
        cmd.div_step = (state_reg == meu_pkg::ST_DIV);
        cmd.finish = (state_reg == meu_pkg::ST_FIN);
    end
endmodule

/* rtl/core/meu_dp.sv */
// Datapath: operand capture, ALU, multiplier, restoring divider, hi/lo and result registers.
`timescale 1ns / 1ps
module meu_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  meu_pkg::cmd_t       cmd,
    output meu_pkg::sts_t       sts,
    input  logic [5:0]          s_operation,
    input  logic [31:0]         s_operand_a,
    input  logic [31:0]         s_operand_b,
    input  logic signed [31:0]  s_offset,
    input  logic [31:0]         s_branch_target,
    output logic [2:0]          m_action,
    output logic [31:0]         m_result_value,
    output logic [31:0]         m_result_high,
    output logic [31:0]         m_next_pc,
    output logic [2:0]          m_access_bytes,
    output logic                m_divide_by_zero
);
    localparam int unsigned CNTW = meu_pkg::CNT_W;
    logic [5:0]  op_reg;
    logic [31:0] a_reg, b_reg, off_reg, tgt_reg;
    logic [31:0] hi_reg, lo_reg, hi_next, lo_next;
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic        neg_q_reg, neg_r_reg;

    logic sgn_op;
    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;
    logic [31:0] shifted;

    assign sgn_op = s_operation == meu_pkg::OP_DIV || s_operation == meu_pkg::OP_DIV_HILO ||
                    s_operation == meu_pkg::OP_REM;
    assign mag_a = (sgn_op && s_operand_a[31]) ? 32'(-s_operand_a) : s_operand_a;
    assign mag_b = (sgn_op && s_operand_b[31]) ? 32'(-s_operand_b) : s_operand_b;
    assign shifted = {rem_reg[30:0], quo_reg[31]};
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    assign sts.is_div = meu_pkg::is_div_op(s_operation);
    assign sts.div_last = (cnt_reg == CNTW'(31));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_operation;
            a_reg <= s_operand_a;
            b_reg <= s_operand_b;
            off_reg <= s_offset;
            tgt_reg <= s_branch_target;
        end
        if (cmd.div_start) begin
            quo_reg <= mag_a;
            rem_reg <= '0;
            dvs_reg <= mag_b;
            cnt_reg <= '0;
            neg_q_reg <= sgn_op && (s_operand_a[31] ^ s_operand_b[31]);
            neg_r_reg <= sgn_op && s_operand_a[31];
        end else if (cmd.div_step) begin
            // restoring step: shift in a dividend bit, subtract if it fits
            if (!trial[32]) rem_reg <= trial[31:0];
            else rem_reg <= shifted;
            quo_reg <= {quo_reg[30:0], ~trial[32]};
            cnt_reg <= cnt_reg + CNTW'(1);
        end
    end

    // result forming
    logic [63:0] prod_u;
    logic [31:0] ph_s, q_f, r_f;
    logic        dz, lt_ab, lt_ba;
    logic        cond, is_br;
    logic [2:0]  act_c, bytes_c;
    logic [31:0] val_c, high_c;

    always_comb begin
        prod_u = {32'd0, a_reg} * {32'd0, b_reg};
        ph_s = prod_u[63:32] - (a_reg[31] ? b_reg : 32'd0) - (b_reg[31] ? a_reg : 32'd0);
        dz = (b_reg == '0);
        q_f = dz ? '0 : (neg_q_reg ? 32'(-quo_reg) : quo_reg);
        r_f = dz ? '0 : (neg_r_reg ? 32'(-rem_reg) : rem_reg);
        lt_ab = (a_reg ^ 32'h8000_0000) < (b_reg ^ 32'h8000_0000);
        lt_ba = (b_reg ^ 32'h8000_0000) < (a_reg ^ 32'h8000_0000);
        act_c = meu_pkg::ACT_REG;
        val_c = '0;
        high_c = '0;
        bytes_c = '0;
        cond = 1'b0;
        is_br = 1'b0;
        hi_next = hi_reg;
        lo_next = lo_reg;
        unique case (op_reg)
            meu_pkg::OP_ADD, meu_pkg::OP_ADDU: val_c = a_reg + b_reg;
            meu_pkg::OP_SUB, meu_pkg::OP_SUBU: val_c = a_reg - b_reg;
            meu_pkg::OP_MUL, meu_pkg::OP_MULU: val_c = prod_u[31:0];
            meu_pkg::OP_MULT, meu_pkg::OP_MULTU: begin
                act_c = meu_pkg::ACT_HILO;
                val_c = prod_u[31:0];
                high_c = (op_reg == meu_pkg::OP_MULT) ? ph_s : prod_u[63:32];
                lo_next = val_c;
                hi_next = high_c;
            end
            meu_pkg::OP_DIV, meu_pkg::OP_DIVU: val_c = q_f;
            meu_pkg::OP_REM, meu_pkg::OP_REMU: val_c = r_f;
            meu_pkg::OP_DIV_HILO, meu_pkg::OP_DIVU_HILO: begin
                act_c = meu_pkg::ACT_HILO;
                val_c = q_f;
                high_c = r_f;
                lo_next = q_f;
                hi_next = r_f;
            end
            meu_pkg::OP_XOR: val_c = a_reg ^ b_reg;
            meu_pkg::OP_NEG: val_c = 32'(-a_reg);
            meu_pkg::OP_SEQ: val_c = 32'(a_reg == b_reg);
            meu_pkg::OP_SGE: val_c = 32'(!lt_ab);
            meu_pkg::OP_SGT: val_c = 32'(lt_ba);
            meu_pkg::OP_SLE: val_c = 32'(!lt_ba);
            meu_pkg::OP_SLT: val_c = 32'(lt_ab);
            meu_pkg::OP_SNE: val_c = 32'(a_reg != b_reg);
            meu_pkg::OP_BEQ: begin is_br = 1'b1; cond = a_reg == b_reg; end
            meu_pkg::OP_BNE: begin is_br = 1'b1; cond = a_reg != b_reg; end
            meu_pkg::OP_BGE: begin is_br = 1'b1; cond = !lt_ab; end
            meu_pkg::OP_BLE: begin is_br = 1'b1; cond = !lt_ba; end
            meu_pkg::OP_BGT: begin is_br = 1'b1; cond = lt_ba; end
            meu_pkg::OP_BLT: begin is_br = 1'b1; cond = lt_ab; end
            meu_pkg::OP_BEQZ: begin is_br = 1'b1; cond = a_reg == '0; end
            meu_pkg::OP_BNEZ: begin is_br = 1'b1; cond = a_reg != '0; end
            meu_pkg::OP_BLEZ: begin is_br = 1'b1; cond = a_reg == '0 || a_reg[31]; end
            meu_pkg::OP_BGEZ: begin is_br = 1'b1; cond = !a_reg[31]; end
            meu_pkg::OP_BGTZ: begin is_br = 1'b1; cond = a_reg != '0 && !a_reg[31]; end
            meu_pkg::OP_BLTZ: begin is_br = 1'b1; cond = a_reg[31]; end
            meu_pkg::OP_JUMP: begin is_br = 1'b1; cond = 1'b1; end
            meu_pkg::OP_LA, meu_pkg::OP_LB, meu_pkg::OP_LH, meu_pkg::OP_LW: begin
                act_c = meu_pkg::ACT_LOAD;
                val_c = a_reg + off_reg;
                bytes_c = (op_reg == meu_pkg::OP_LA) ? 3'd0 :
                          (op_reg == meu_pkg::OP_LB) ? 3'd1 :
                          (op_reg == meu_pkg::OP_LH) ? 3'd2 : 3'd4;
            end
            meu_pkg::OP_SB, meu_pkg::OP_SH, meu_pkg::OP_SW: begin
                act_c = meu_pkg::ACT_STORE;
                val_c = a_reg + off_reg;
                high_c = b_reg;
                bytes_c = (op_reg == meu_pkg::OP_SB) ? 3'd1 :
                          (op_reg == meu_pkg::OP_SH) ? 3'd2 : 3'd4;
            end
            meu_pkg::OP_MOVE: val_c = a_reg;
            meu_pkg::OP_MFHI: val_c = hi_reg;
            meu_pkg::OP_MFLO: val_c = lo_reg;
            default: act_c = meu_pkg::ACT_NOT_TAKEN;
        endcase
        if (is_br) begin
            act_c = cond ? meu_pkg::ACT_TAKEN : meu_pkg::ACT_NOT_TAKEN;
            val_c = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else if (cmd.finish) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_action <= act_c;
            m_result_value <= val_c;
            m_result_high <= high_c;
            m_next_pc <= (is_br && cond) ? tgt_reg : '0;
            m_access_bytes <= bytes_c;
            m_divide_by_zero <= meu_pkg::is_div_op(op_reg) && dz;
        end
    end
endmodule

/* rtl/core/mips_execute_unit.sv */
// Top level of the execute unit: controller plus datapath.
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    operation, operand_a, operand_b, offset, branch_target
//   m_       out        m_valid / m_ready    action, result_value, result_high, next_pc,
//                                            access_bytes, divide_by_zero
// Non-divide requests pass from acceptance through ST_FIN to ST_OUT, where m_valid rises;
// divide and remainder requests first pass through ST_DIV for the
// 32 iterations of the shared restoring divider.
// One request is in flight at a time; s_ready returns the cycle after the result is taken.
// Synchronous active-low reset clears the controller and hi/lo.
// A stalled result holds in the output register until m_ready.
`timescale 1ns / 1ps
module mips_execute_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [5:0]          s_operation,
    input  logic [31:0]         s_operand_a,
    input  logic [31:0]         s_operand_b,
    input  logic signed [31:0]  s_offset,
    input  logic [31:0]         s_branch_target,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_action,
    output logic [31:0]         m_result_value,
    output logic [31:0]         m_result_high,
    output logic [31:0]         m_next_pc,
    output logic [2:0]          m_access_bytes,
    output logic                m_divide_by_zero
);
    meu_pkg::cmd_t cmd;
    meu_pkg::sts_t sts;

    meu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    meu_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_operation(s_operation), .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .s_offset(s_offset), .s_branch_target(s_branch_target),
        .m_action(m_action), .m_result_value(m_result_value),
        .m_result_high(m_result_high), .m_next_pc(m_next_pc),
        .m_access_bytes(m_access_bytes), .m_divide_by_zero(m_divide_by_zero)
    );
endmodule

/* rtl/core/meu_checker.sv */
// Port checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
module meu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_action,
    input logic [31:0] m_result_value,
    input logic [31:0] m_next_pc
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("result dropped or changed under stall");
    a_pc_only_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != meu_pkg::ACT_TAKEN |-> m_next_pc == '0)
        else $error("next_pc set without taken branch");
    a_no_result_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind mips_execute_unit meu_checker u_meu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_action(m_action),
    .m_result_value(m_result_value), .m_next_pc(m_next_pc)
);
